// File: rtl/mcw_pkg.sv
package mcw_pkg;

	localparam int CW = 13;
	localparam logic [CW-1:0] COUNT_MAX = 13'd8191;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic        found;
		logic [11:0] best_start;
		logic [12:0] best_length;
		logic        overflow;
	} out_word_t;

endpackage

// File: rtl/mcw_engine.sv
module mcw_engine #(
	parameter int MAX_TEXT = 4096,
	parameter int ALPHABET = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mcw_pkg::in_word_t item,
	input  logic              out_free,
	output logic              busy,
	output logic              done,
	output mcw_pkg::out_word_t word
);
	import mcw_pkg::*;

	localparam int PW = $clog2(MAX_TEXT);
	localparam int LW = $clog2(MAX_TEXT + 1);
	localparam int AW = $clog2(ALPHABET);
	localparam int SW = $clog2(ALPHABET + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_PAT  = 3'd2;
	localparam logic [2:0] ST_TXT  = 3'd3;
	localparam logic [2:0] ST_LTXT = 3'd4;
	localparam logic [2:0] ST_LCNT = 3'd5;
	localparam logic [2:0] ST_LDEC = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0]    state_q;
	logic          op_q;
	logic [7:0]    sym_q;
	logic [LW-1:0] text_len_q;
	logic [PW-1:0] left_q;
	logic [PW-1:0] right_q;
	logic [SW-1:0] short_q;
	logic [PW-1:0] best_begin_q;
	logic [LW-1:0] best_len_q;
	logic          found_q;
	logic          ovf_q;

	// count store: required count above, window count below
	logic [2*CW-1:0] cnt_mem [ALPHABET];
	logic [ALPHABET-1:0] cnt_vld_q;
	logic [2*CW-1:0] cnt_rdata_q;
	logic            cnt_rvld_q;
	logic [7:0]      txt_mem [MAX_TEXT];
	logic [7:0]      txt_rdata_q;

	logic            cnt_re, cnt_we, txt_we, txt_re;
	logic [AW-1:0]   cnt_raddr, cnt_waddr;
	logic [2*CW-1:0] cnt_wdata;

	logic          sym_ok, txt_full, short_dec, drop;
	logic [AW-1:0] sym_idx, ls_idx;
	logic [CW-1:0] req_rd, win_rd, new_req, new_win;
	logic [SW-1:0] short_next;
	logic [LW-1:0] cand_len;
	logic [PW-1:0] cand_start;

	assign sym_ok   = {1'b0, sym_q} < 9'(ALPHABET);
	assign sym_idx  = sym_q[AW-1:0];
	assign ls_idx   = txt_rdata_q[AW-1:0];
	assign txt_full = text_len_q == LW'(MAX_TEXT);
	assign req_rd   = cnt_rvld_q ? cnt_rdata_q[2*CW-1:CW] : '0;
	assign win_rd   = cnt_rvld_q ? cnt_rdata_q[CW-1:0] : '0;
	assign new_req  = req_rd + 1'b1;
	assign new_win  = win_rd + 1'b1;
	assign short_dec = (win_rd != COUNT_MAX) && (req_rd != '0) && (new_win == req_rd);
	assign short_next = short_q - SW'(short_dec);
	assign drop = (left_q != right_q) && !((req_rd != '0) && (win_rd <= req_rd));
	assign cand_len   = (req_rd == '0) ? '0 : LW'(right_q) - LW'(left_q) + 1'b1;
	assign cand_start = (req_rd == '0) ? '0 : left_q;

	always_comb begin
		cnt_re    = 1'b0;
		cnt_we    = 1'b0;
		txt_we    = 1'b0;
		txt_re    = 1'b0;
		cnt_raddr = sym_idx;
		cnt_waddr = sym_idx;
		cnt_wdata = {req_rd, win_rd};
		case (state_q)
			ST_DISP: begin
				if (sym_ok && op_q == OP_PATTERN && text_len_q == '0) begin
					cnt_re = 1'b1;
				end else if (sym_ok && op_q == OP_TEXT && !txt_full) begin
					cnt_re = 1'b1;
					txt_we = 1'b1;
				end
			end
			ST_PAT: begin
				cnt_we    = req_rd != COUNT_MAX;
				cnt_wdata = {new_req, win_rd};
			end
			ST_TXT: begin
				cnt_we    = win_rd != COUNT_MAX;
				cnt_wdata = {req_rd, new_win};
			end
			ST_LTXT: txt_re = 1'b1;
			ST_LCNT: begin
				cnt_re    = 1'b1;
				cnt_raddr = ls_idx;
			end
			ST_LDEC: begin
				cnt_we    = drop;
				cnt_waddr = ls_idx;
				cnt_wdata = {req_rd, win_rd - 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rdata_q <= cnt_mem[cnt_raddr];
		end
		if (txt_we) begin
			txt_mem[text_len_q[PW-1:0]] <= sym_q;
		end
		if (txt_re) begin
			txt_rdata_q <= txt_mem[left_q];
		end
	end

	// unwritten count entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q  <= '0;
			cnt_rvld_q <= 1'b0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
			if (cnt_re) begin
				cnt_rvld_q <= cnt_vld_q[cnt_raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= 1'b0;
			sym_q        <= '0;
			text_len_q   <= '0;
			left_q       <= '0;
			right_q      <= '0;
			short_q      <= '0;
			best_begin_q <= '0;
			best_len_q   <= '0;
			found_q      <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= item.op;
						sym_q   <= item.symbol;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (!sym_ok) begin
						state_q <= ST_EMIT;
					end else if (op_q == OP_PATTERN) begin
						state_q <= (text_len_q == '0) ? ST_PAT : ST_EMIT;
					end else if (txt_full) begin
						ovf_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						text_len_q <= text_len_q + 1'b1;
						right_q    <= text_len_q[PW-1:0];
						state_q    <= ST_TXT;
					end
				end
				ST_PAT: begin
					if (req_rd == '0) begin
						short_q <= short_q + 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_TXT: begin
					short_q <= short_next;
					state_q <= (short_next != '0) ? ST_EMIT : ST_LTXT;
				end
				ST_LTXT: state_q <= ST_LCNT;
				ST_LCNT: state_q <= ST_LDEC;
				ST_LDEC: begin
					if (drop) begin
						left_q  <= left_q + 1'b1;
						state_q <= ST_LTXT;
					end else begin
						if (!found_q || cand_len < best_len_q) begin
							found_q      <= 1'b1;
							best_len_q   <= cand_len;
							best_begin_q <= cand_start;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = (state_q == ST_EMIT) && out_free;

	assign word.found       = found_q;
	assign word.best_start  = 12'(best_begin_q);
	assign word.best_length = 13'(best_len_q);
	assign word.overflow    = ovf_q;

endmodule

// File: rtl/minimum_covering_window.sv
// Minimum covering window. Pattern words (op 0) build required symbol counts
// until the first text word arrives; text words (op 1) are appended one by one,
// and each word of either kind returns one result word: whether a covering
// window has been seen, the start and length of the earliest shortest one, and
// a sticky overflow flag set once text beyond MAX_TEXT symbols was dropped.
// Counts live in one synchronous memory of ALPHABET entries and the text in a
// second of MAX_TEXT entries; each word is handled on its own. A pattern word
// taken before any text, or a text word that leaves the window uncovered, passes
// through dispatch, a count update and emit; a pattern word after text began or
// a text word dropped for capacity goes from dispatch straight to emit. A covered
// text word then checks the left edge once for each symbol it moves past and once
// more: every check is a text read and a count read, plus a count write-back when
// the edge moves. Since the left edge only moves forward, it moves past at most
// one symbol per text word on average. A finished result waits in an output
// register while the next word is taken; while that register is full and stalled,
// the engine holds its result and takes no new word.
module minimum_covering_window #(
	parameter int MAX_TEXT = 4096,
	parameter int ALPHABET = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  mcw_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output mcw_pkg::out_word_t result
);
	import mcw_pkg::*;

	logic      busy, done, out_free;
	logic      result_valid_q;
	out_word_t word;
	out_word_t result_q;

	assign item_stall = busy;
	assign out_free   = !result_valid_q || !result_stall;

	mcw_engine #(
		.MAX_TEXT(MAX_TEXT),
		.ALPHABET(ALPHABET)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (item_valid && !busy),
		.item     (item),
		.out_free (out_free),
		.busy     (busy),
		.done     (done),
		.word     (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			result_q <= word;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/mcw_checker.sv
module mcw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input mcw_pkg::out_word_t result
);
	import mcw_pkg::*;

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("word accepted while another is in flight");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |=> result.found)
		else $error("found cleared after being set");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |=> result.overflow)
		else $error("overflow cleared after being set");

	a_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.best_start == '0 && result.best_length == '0)
		else $error("window reported before any was found");

endmodule

bind minimum_covering_window mcw_checker u_mcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
